### rtl/gbfr_pkg.sv
// Shared types and constants for the binary GNSS frame receiver.
package gbfr_pkg;

    localparam int DEFAULT_MAX_FRAME_BYTES = 1024;

    // Frame framing bytes and message codes
    localparam logic [7:0] SYNC_A  = 8'hB5;
    localparam logic [7:0] SYNC_B  = 8'h62;
    localparam logic [7:0] CLS_NAV = 8'h01;
    localparam logic [7:0] ID_PVT  = 8'h07;
    localparam logic [7:0] CLS_ACK = 8'h05;
    localparam logic [7:0] ID_ACK  = 8'h01;
    localparam logic [7:0] ID_NAK  = 8'h00;

    localparam logic [16:0] HDR_BYTES = 17'd6;
    localparam logic [15:0] ACK_LEN   = 16'd2;

    // Configuration register map (word index)
    localparam int          APB_ADDR_W    = 4;
    localparam logic [1:0]  REG_ACK_CLASS = 2'd0;
    localparam logic [1:0]  REG_ACK_ID    = 2'd1;
    localparam logic [1:0]  REG_COPY_LIM  = 2'd2;

    localparam logic [7:0] RST_ACK_CLASS = 8'd6;
    localparam logic [7:0] RST_ACK_ID    = 8'd138;
    localparam logic [9:0] RST_COPY_LIM  = 10'd92;

    typedef enum logic [8:0] {
        PH_SYNC1   = 9'b000000001,
        PH_SYNC2   = 9'b000000010,
        PH_CLASS   = 9'b000000100,
        PH_ID      = 9'b000001000,
        PH_LEN_LO  = 9'b000010000,
        PH_LEN_HI  = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_CK_A    = 9'b010000000,
        PH_CK_B    = 9'b100000000
    } phase_t;

    typedef enum logic [2:0] {
        EV_PVT_BYTE  = 3'd0,
        EV_PVT_END   = 3'd1,
        EV_ACK       = 3'd2,
        EV_NAK       = 3'd3,
        EV_OTHER_END = 3'd4,
        EV_OVERSIZE  = 3'd5
    } event_t;

    typedef struct packed {
        logic [7:0] ack_class;
        logic [7:0] ack_id;
        logic [9:0] copy_limit;
    } cfg_t;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  data_byte;
        logic [9:0]  byte_index;
        logic [7:0]  frame_class;
        logic [7:0]  frame_id;
        logic [15:0] frame_length;
        logic        checksum_ok;
    } res_t;

endpackage

### rtl/gbfr_ifs.sv
// Valid/ready channel interfaces for received bytes and frame events.
interface gbfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface gbfr_event_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    logic        checksum_ok;

    modport source (output valid, output event_res, output data_byte, output byte_index,
                    output frame_class, output frame_id, output frame_length,
                    output checksum_ok, input ready);
    modport sink (input valid, input event_res, input data_byte, input byte_index,
                  input frame_class, input frame_id, input frame_length,
                  input checksum_ok, output ready);
endinterface

### rtl/gnss_binary_frame_receiver.sv
// Top level: APB config registers, byte input channel, registered event output.
//
// Usage:
//   rx  (sink)   : one received serial byte per request, valid/ready.
//   res (source) : frame events, valid/ready; at most one event per byte.
//   APB          : three write/read registers at byte offsets 0, 4, 8
//                  (awaited ack class, awaited ack id, position payload copy limit).
//                  pready is tied high; write only while the block is idle.
// Events: an event appears on res in the cycle after the byte that causes it
//   is accepted; bytes that cause no event leave nothing on res.
// Throughput: one byte per cycle while res is not stalled; the only storage
//   between the channels is the single event output register.
// Stall: while an event sits in the output register and res.ready is low,
//   rx.ready drops; a byte is still taken in the cycle the event drains.
// Reset (rst_n low, async): parser hunts for the first sync byte, output
//   register empties, config returns to 6 / 138 / 92.
module gnss_binary_frame_receiver #(
    parameter int MAX_FRAME_BYTES = gbfr_pkg::DEFAULT_MAX_FRAME_BYTES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    gbfr_byte_if.sink                       rx,
    gbfr_event_if.source                    res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gbfr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    gbfr_pkg::cfg_t cfg_reg, cfg_next;
    gbfr_pkg::res_t out_reg;
    gbfr_pkg::res_t result;
    logic           out_valid_reg, out_valid_next;
    logic           in_fire, emit, cfg_write;
    logic [1:0]     reg_sel;

    // ------------------------------------------------------------------
    // Config port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_sel   = paddr[gbfr_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                gbfr_pkg::REG_ACK_CLASS: cfg_next.ack_class  = pwdata[7:0];
                gbfr_pkg::REG_ACK_ID:    cfg_next.ack_id     = pwdata[7:0];
                gbfr_pkg::REG_COPY_LIM:  cfg_next.copy_limit = pwdata[9:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            gbfr_pkg::REG_ACK_CLASS: prdata = {24'd0, cfg_reg.ack_class};
            gbfr_pkg::REG_ACK_ID:    prdata = {24'd0, cfg_reg.ack_id};
            gbfr_pkg::REG_COPY_LIM:  prdata = {22'd0, cfg_reg.copy_limit};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_class  <= gbfr_pkg::RST_ACK_CLASS;
            cfg_reg.ack_id     <= gbfr_pkg::RST_ACK_ID;
            cfg_reg.copy_limit <= gbfr_pkg::RST_COPY_LIM;
        end
        else
            cfg_reg <= cfg_next;
    end

    // ------------------------------------------------------------------
    // Input request handshake: take a byte whenever the output register
    // is empty or draining this cycle
    // ------------------------------------------------------------------
    assign rx.ready = !out_valid_reg || res.ready;
    assign in_fire  = rx.valid && rx.ready;

    gbfr_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .in_byte (rx.rx_byte),
        .cfg     (cfg_reg),
        .emit    (emit),
        .result  (result)
    );

    // ------------------------------------------------------------------
    // Event output register
    // ------------------------------------------------------------------
    always_comb
    begin
        if (in_fire && emit)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // payload only, loads with each new event
    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
            out_reg <= result;
    end

    assign res.valid        = out_valid_reg;
    assign res.event_res    = out_reg.ev;
    assign res.data_byte    = out_reg.data_byte;
    assign res.byte_index   = out_reg.byte_index;
    assign res.frame_class  = out_reg.frame_class;
    assign res.frame_id     = out_reg.frame_id;
    assign res.frame_length = out_reg.frame_length;
    assign res.checksum_ok  = out_reg.checksum_ok;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // payload data and offset are zero on every non-payload event
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.ev != gbfr_pkg::EV_PVT_BYTE)
            |-> (out_reg.data_byte == 8'd0) && (out_reg.byte_index == 10'd0))
        else $error("non-payload event carries payload data");

    // ack and nak only for a checked two-byte ack-class frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ((out_reg.ev == gbfr_pkg::EV_ACK) || (out_reg.ev == gbfr_pkg::EV_NAK))
            |-> out_reg.checksum_ok && (out_reg.frame_class == gbfr_pkg::CLS_ACK)
                && (out_reg.frame_length == gbfr_pkg::ACK_LEN))
        else $error("ack/nak reported for an unqualified frame");

    // position payload bytes stay below the copy limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.ev == gbfr_pkg::EV_PVT_BYTE)
            |-> (out_reg.byte_index < cfg_reg.copy_limit) && !out_reg.checksum_ok)
        else $error("payload byte passed beyond copy limit");

    // a held event is never overwritten by a new one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res.ready |-> !in_fire)
        else $error("byte accepted while event output stalled");

endmodule

### rtl/gbfr_parser.sv
// Frame parser: phase machine, header capture, Fletcher sums, event decode.
module gbfr_parser #(
    parameter int MAX_FRAME_BYTES = gbfr_pkg::DEFAULT_MAX_FRAME_BYTES
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic [7:0]      in_byte,
    input  gbfr_pkg::cfg_t  cfg,
    output logic            emit,
    output gbfr_pkg::res_t  result
);

    // Accepted payload never exceeds MAX_FRAME_BYTES - 6, so this count fits
    localparam int          CNT_W     = $clog2(MAX_FRAME_BYTES);
    localparam logic [16:0] MAX_TOTAL = 17'(MAX_FRAME_BYTES);

    gbfr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       class_reg, class_next;
    logic [7:0]       id_reg, id_next;
    logic [15:0]      length_reg, length_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sum_a_reg, sum_a_next;
    logic [7:0]       sum_b_reg, sum_b_next;
    logic [15:0]      ack_payload_reg, ack_payload_next;
    logic [7:0]       ck_a_reg, ck_a_next;

    logic [7:0]       base_a, base_b, add_a, add_b;
    logic [CNT_W-1:0] count_inc;
    logic [15:0]      len_full;
    logic             pvt_frame, ck_match, ack_match;

    // Running Fletcher sum; restarts at the class byte
    assign base_a    = (phase_reg == gbfr_pkg::PH_CLASS) ? 8'd0 : sum_a_reg;
    assign base_b    = (phase_reg == gbfr_pkg::PH_CLASS) ? 8'd0 : sum_b_reg;
    assign add_a     = base_a + in_byte;
    assign add_b     = base_b + add_a;
    assign count_inc = count_reg + 1'b1;
    assign len_full  = {in_byte, length_reg[7:0]};
    assign pvt_frame = (class_reg == gbfr_pkg::CLS_NAV) && (id_reg == gbfr_pkg::ID_PVT);
    assign ck_match  = (ck_a_reg == sum_a_reg) && (in_byte == sum_b_reg);
    assign ack_match = ck_match && (class_reg == gbfr_pkg::CLS_ACK)
                       && (length_reg == gbfr_pkg::ACK_LEN)
                       && (ack_payload_reg[7:0] == cfg.ack_class)
                       && (ack_payload_reg[15:8] == cfg.ack_id);

    always_comb
    begin
        phase_next       = phase_reg;
        class_next       = class_reg;
        id_next          = id_reg;
        length_next      = length_reg;
        count_next       = count_reg;
        sum_a_next       = sum_a_reg;
        sum_b_next       = sum_b_reg;
        ack_payload_next = ack_payload_reg;
        ck_a_next        = ck_a_reg;
        emit                = 1'b0;
        result.ev           = gbfr_pkg::EV_OTHER_END;
        result.data_byte    = 8'd0;
        result.byte_index   = 10'd0;
        result.frame_class  = class_reg;
        result.frame_id     = id_reg;
        result.frame_length = length_reg;
        result.checksum_ok  = 1'b0;
        if (in_fire)
        begin
            unique case (phase_reg)
                gbfr_pkg::PH_SYNC1:
                begin
                    if (in_byte == gbfr_pkg::SYNC_A)
                        phase_next = gbfr_pkg::PH_SYNC2;
                end
                gbfr_pkg::PH_SYNC2:
                begin
                    // a repeated first sync byte keeps waiting for the second
                    if (in_byte == gbfr_pkg::SYNC_B)
                        phase_next = gbfr_pkg::PH_CLASS;
                    else if (in_byte != gbfr_pkg::SYNC_A)
                        phase_next = gbfr_pkg::PH_SYNC1;
                end
                gbfr_pkg::PH_CLASS:
                begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    class_next = in_byte;
                    phase_next = gbfr_pkg::PH_ID;
                end
                gbfr_pkg::PH_ID:
                begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    id_next    = in_byte;
                    phase_next = gbfr_pkg::PH_LEN_LO;
                end
                gbfr_pkg::PH_LEN_LO:
                begin
                    sum_a_next  = add_a;
                    sum_b_next  = add_b;
                    length_next = {8'd0, in_byte};
                    phase_next  = gbfr_pkg::PH_LEN_HI;
                end
                gbfr_pkg::PH_LEN_HI:
                begin
                    sum_a_next          = add_a;
                    sum_b_next          = add_b;
                    length_next         = len_full;
                    count_next          = '0;
                    ack_payload_next    = 16'd0;
                    result.frame_length = len_full;
                    if (({1'b0, len_full} + gbfr_pkg::HDR_BYTES) > MAX_TOTAL)
                    begin
                        phase_next = gbfr_pkg::PH_SYNC1;
                        emit       = 1'b1;
                        result.ev  = gbfr_pkg::EV_OVERSIZE;
                    end
                    else if (len_full == 16'd0)
                        phase_next = gbfr_pkg::PH_CK_A;
                    else
                        phase_next = gbfr_pkg::PH_PAYLOAD;
                end
                gbfr_pkg::PH_PAYLOAD:
                begin
                    sum_a_next = add_a;
                    sum_b_next = add_b;
                    count_next = count_inc;
                    if (count_reg == '0)
                        ack_payload_next[7:0] = in_byte;
                    else if (count_reg == CNT_W'(1))
                        ack_payload_next[15:8] = in_byte;
                    if (16'(count_inc) >= length_reg)
                        phase_next = gbfr_pkg::PH_CK_A;
                    if (pvt_frame && (16'(count_reg) < 16'(cfg.copy_limit)))
                    begin
                        emit              = 1'b1;
                        result.ev         = gbfr_pkg::EV_PVT_BYTE;
                        result.data_byte  = in_byte;
                        result.byte_index = 10'(count_reg);
                    end
                end
                gbfr_pkg::PH_CK_A:
                begin
                    ck_a_next  = in_byte;
                    phase_next = gbfr_pkg::PH_CK_B;
                end
                gbfr_pkg::PH_CK_B:
                begin
                    phase_next         = gbfr_pkg::PH_SYNC1;
                    emit               = 1'b1;
                    result.checksum_ok = ck_match;
                    if (pvt_frame)
                        result.ev = gbfr_pkg::EV_PVT_END;
                    else if (ack_match && (id_reg == gbfr_pkg::ID_ACK))
                        result.ev = gbfr_pkg::EV_ACK;
                    else if (ack_match && (id_reg == gbfr_pkg::ID_NAK))
                        result.ev = gbfr_pkg::EV_NAK;
                end
                default:
                    phase_next = gbfr_pkg::PH_SYNC1;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= gbfr_pkg::PH_SYNC1;
            class_reg       <= 8'd0;
            id_reg          <= 8'd0;
            length_reg      <= 16'd0;
            count_reg       <= '0;
            sum_a_reg       <= 8'd0;
            sum_b_reg       <= 8'd0;
            ack_payload_reg <= 16'd0;
            ck_a_reg        <= 8'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            class_reg       <= class_next;
            id_reg          <= id_next;
            length_reg      <= length_next;
            count_reg       <= count_next;
            sum_a_reg       <= sum_a_next;
            sum_b_reg       <= sum_b_next;
            ack_payload_reg <= ack_payload_next;
            ck_a_reg        <= ck_a_next;
        end
    end

    // payload offset never passes the header length
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == gbfr_pkg::PH_PAYLOAD) |-> (16'(count_reg) < length_reg))
        else $error("payload count ran past frame length");

    // an oversize length never reaches the payload phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == gbfr_pkg::PH_PAYLOAD) |->
            (({1'b0, length_reg} + gbfr_pkg::HDR_BYTES) <= MAX_TOTAL))
        else $error("oversize frame entered payload phase");

    // checksum bytes follow the payload only once it is complete
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == gbfr_pkg::PH_CK_A) && $past(phase_reg == gbfr_pkg::PH_PAYLOAD)
            |-> (16'(count_reg) == length_reg))
        else $error("checksum phase entered with payload outstanding");

endmodule

### tb/gnss_binary_frame_receiver_tb.sv
// Self-checking testbench for the GNSS frame receiver: stimulus, parser model, scoreboard.
module gnss_binary_frame_receiver_tb;

    localparam int MAX_FRAME   = gbfr_pkg::DEFAULT_MAX_FRAME_BYTES;
    // Largest payload that still fits in one frame.
    localparam int MAX_PAYLOAD = MAX_FRAME - int'(gbfr_pkg::HDR_BYTES);
    // Each random phase queues frames until at least this many frame bytes were added since it began.
    localparam int PHASE_BYTES = 40;
    localparam int NUM_PHASES  = 5;
    localparam int TIMEOUT     = 5000000;

    logic clk;
    logic rst_n;

    // APB configuration port
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [gbfr_pkg::APB_ADDR_W-1:0] paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    gbfr_byte_if  rx_ch ();
    gbfr_event_if ev_ch ();

    gnss_binary_frame_receiver #(
        .MAX_FRAME_BYTES (MAX_FRAME)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .res     (ev_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Bytes still to be sent; the front entry is the one on the bus while valid is high.
    logic [7:0]     rx_pending[$];
    // Events the parser model says the block must produce, oldest first.
    gbfr_pkg::res_t expected_events[$];
    // Scratch payload handed to queue_frame.
    logic [7:0]     body_q[$];

    int  fail_count;
    int  frame_bytes;   // bytes of frames and broken frames, idle noise excluded
    int  phase_start;   // frame_bytes when the current random phase began
    bit  rx_fired;      // request taken at the last rising edge
    bit  quiet_tail;    // no idling on either side from here on
    int  src_gap;
    int  src_calm;
    int  snk_gap;
    int  snk_calm;

    // ------------------------------------------------------------------
    // Parser model: its own copy of the configuration and parse state.
    // ------------------------------------------------------------------
    gbfr_pkg::cfg_t   rx_cfg;
    gbfr_pkg::phase_t rx_phase;
    logic [7:0]       hdr_class;
    logic [7:0]       hdr_id;
    logic [15:0]      hdr_len;
    logic [15:0]      pay_count;
    logic [7:0]       fl_a;
    logic [7:0]       fl_b;
    logic [15:0]      ack_word;   // first payload byte low, second high
    logic [7:0]       got_ck_a;

    task automatic model_reset();
        rx_cfg.ack_class  = gbfr_pkg::RST_ACK_CLASS;
        rx_cfg.ack_id     = gbfr_pkg::RST_ACK_ID;
        rx_cfg.copy_limit = gbfr_pkg::RST_COPY_LIM;
        rx_phase  = gbfr_pkg::PH_SYNC1;
        hdr_class = '0;
        hdr_id    = '0;
        hdr_len   = '0;
        pay_count = '0;
        fl_a      = '0;
        fl_b      = '0;
        ack_word  = '0;
        got_ck_a  = '0;
    endtask

    // Fletcher running sums over class, id, length and payload.
    function automatic void fletcher_add(input logic [7:0] b);
        fl_a = fl_a + b;
        fl_b = fl_b + fl_a;
    endfunction

    // Advances the model by one received byte; returns 1 when the byte yields an event.
    function automatic bit parse_rx_byte(input logic [7:0] b, output gbfr_pkg::res_t ev_out);
        logic [15:0] idx;
        bit          ck_good;
        bit          fired;
        fired  = 1'b0;
        ev_out = '0;
        case (rx_phase)
            gbfr_pkg::PH_SYNC1:
                if (b == gbfr_pkg::SYNC_A)
                    rx_phase = gbfr_pkg::PH_SYNC2;
            gbfr_pkg::PH_SYNC2:
                // another first sync byte keeps us waiting for the second one
                if (b == gbfr_pkg::SYNC_B)
                    rx_phase = gbfr_pkg::PH_CLASS;
                else if (b != gbfr_pkg::SYNC_A)
                    rx_phase = gbfr_pkg::PH_SYNC1;
            gbfr_pkg::PH_CLASS: begin
                fl_a = '0;
                fl_b = '0;
                fletcher_add(b);
                hdr_class = b;
                rx_phase  = gbfr_pkg::PH_ID;
            end
            gbfr_pkg::PH_ID: begin
                fletcher_add(b);
                hdr_id   = b;
                rx_phase = gbfr_pkg::PH_LEN_LO;
            end
            gbfr_pkg::PH_LEN_LO: begin
                fletcher_add(b);
                hdr_len  = {8'h00, b};
                rx_phase = gbfr_pkg::PH_LEN_HI;
            end
            gbfr_pkg::PH_LEN_HI: begin
                fletcher_add(b);
                hdr_len[15:8] = b;
                pay_count = '0;
                ack_word  = '0;
                if (int'(hdr_len) + int'(gbfr_pkg::HDR_BYTES) > MAX_FRAME) begin
                    // too big: drop it, hunt again starting with the next byte
                    rx_phase  = gbfr_pkg::PH_SYNC1;
                    ev_out.ev = gbfr_pkg::EV_OVERSIZE;
                    fired     = 1'b1;
                end
                else
                    rx_phase = (hdr_len == 16'd0) ? gbfr_pkg::PH_CK_A : gbfr_pkg::PH_PAYLOAD;
            end
            gbfr_pkg::PH_PAYLOAD: begin
                idx = pay_count;
                fletcher_add(b);
                if (idx == 16'd0)
                    ack_word[7:0] = b;
                else if (idx == 16'd1)
                    ack_word[15:8] = b;
                pay_count = pay_count + 16'd1;
                if (pay_count >= hdr_len)
                    rx_phase = gbfr_pkg::PH_CK_A;
                if (hdr_class == gbfr_pkg::CLS_NAV && hdr_id == gbfr_pkg::ID_PVT &&
                    idx < {6'd0, rx_cfg.copy_limit}) begin
                    ev_out.ev         = gbfr_pkg::EV_PVT_BYTE;
                    ev_out.data_byte  = b;
                    ev_out.byte_index = idx[9:0];
                    fired             = 1'b1;
                end
            end
            gbfr_pkg::PH_CK_A: begin
                got_ck_a = b;
                rx_phase = gbfr_pkg::PH_CK_B;
            end
            gbfr_pkg::PH_CK_B: begin
                rx_phase = gbfr_pkg::PH_SYNC1;
                ck_good  = (got_ck_a == fl_a) && (b == fl_b);
                ev_out.ev = gbfr_pkg::EV_OTHER_END;
                if (hdr_class == gbfr_pkg::CLS_NAV && hdr_id == gbfr_pkg::ID_PVT)
                    ev_out.ev = gbfr_pkg::EV_PVT_END;
                else if (ck_good && hdr_class == gbfr_pkg::CLS_ACK &&
                         hdr_len == gbfr_pkg::ACK_LEN &&
                         ack_word[7:0] == rx_cfg.ack_class &&
                         ack_word[15:8] == rx_cfg.ack_id) begin
                    if (hdr_id == gbfr_pkg::ID_ACK)
                        ev_out.ev = gbfr_pkg::EV_ACK;
                    else if (hdr_id == gbfr_pkg::ID_NAK)
                        ev_out.ev = gbfr_pkg::EV_NAK;
                end
                ev_out.checksum_ok = ck_good;
                fired = 1'b1;
            end
            default:
                rx_phase = gbfr_pkg::PH_SYNC1;
        endcase
        if (fired) begin
            ev_out.frame_class  = hdr_class;
            ev_out.frame_id     = hdr_id;
            ev_out.frame_length = hdr_len;
        end
        return fired;
    endfunction

    // ------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT);
        $display("gnss_binary_frame_receiver_tb NOT OK");
        $finish;
    end

    // Length of the next idle burst; occasionally starts a calm stretch with none.
    function automatic int draw_idle(inout int calm_left);
        if (quiet_tail)
            return 0;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(1, 5);
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // Byte driver: holds each request until taken, then maybe idles.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n && (!rx_ch.valid || rx_fired))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                rx_ch.valid <= 1'b0;
            end
            else if (rx_pending.size() > 0)
            begin
                rx_ch.valid   <= 1'b1;
                rx_ch.rx_byte <= rx_pending[0];
                src_gap = draw_idle(src_calm);
            end
            else
                rx_ch.valid <= 1'b0;
        end
    end

    // Event sink: ready drops in random bursts.
    always @(negedge clk)
    begin
        if (snk_gap > 0 && !quiet_tail)
        begin
            snk_gap--;
            ev_ch.ready <= 1'b0;
        end
        else
        begin
            ev_ch.ready <= 1'b1;
            snk_gap = draw_idle(snk_calm);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: checks taken events against the oldest expectation, then
    // feeds each taken byte to the parser model.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        gbfr_pkg::res_t want_ev;
        gbfr_pkg::res_t next_ev;
        rx_fired = rst_n && rx_ch.valid && rx_ch.ready;
        if (rst_n && ev_ch.valid && ev_ch.ready)
        begin
            if (expected_events.size() == 0)
            begin
                $error("unexpected event %0d, frame class %0d id %0d",
                       ev_ch.event_res, ev_ch.frame_class, ev_ch.frame_id);
                fail_count++;
            end
            else
            begin
                want_ev = expected_events.pop_front();
                check_field("event_res", want_ev.ev, ev_ch.event_res);
                check_field("data_byte", want_ev.data_byte, ev_ch.data_byte);
                check_field("byte_index", want_ev.byte_index, ev_ch.byte_index);
                check_field("frame_class", want_ev.frame_class, ev_ch.frame_class);
                check_field("frame_id", want_ev.frame_id, ev_ch.frame_id);
                check_field("frame_length", want_ev.frame_length, ev_ch.frame_length);
                check_field("checksum_ok", want_ev.checksum_ok, ev_ch.checksum_ok);
            end
        end
        if (rx_fired)
        begin
            if (parse_rx_byte(rx_ch.rx_byte, next_ev))
                expected_events.push_back(next_ev);
            void'(rx_pending.pop_front());
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_noise(input logic [7:0] b);
        rx_pending.push_back(b);
    endtask

    task automatic push_byte(input logic [7:0] b);
        rx_pending.push_back(b);
        frame_bytes++;
    endtask

    task automatic fill_body(input int n);
        body_q.delete();
        repeat (n)
            body_q.push_back($urandom_range(0, 255));
    endtask

    // Sync, header, body_q and checksum; an oversize header is sent alone,
    // since the receiver goes back to hunting right after it.
    task automatic queue_frame(input logic [7:0] cls, input logic [7:0] id,
                               input logic [15:0] len, input bit spoil_ck);
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        logic [7:0] hdr[4];
        ck_a = '0;
        ck_b = '0;
        hdr  = '{cls, id, len[7:0], len[15:8]};
        push_byte(gbfr_pkg::SYNC_A);
        push_byte(gbfr_pkg::SYNC_B);
        foreach (hdr[i])
        begin
            push_byte(hdr[i]);
            ck_a = ck_a + hdr[i];
            ck_b = ck_b + ck_a;
        end
        if (int'(len) + int'(gbfr_pkg::HDR_BYTES) > MAX_FRAME)
        begin
            body_q.delete();
            return;
        end
        foreach (body_q[i])
        begin
            push_byte(body_q[i]);
            ck_a = ck_a + body_q[i];
            ck_b = ck_b + ck_a;
        end
        body_q.delete();
        if (spoil_ck)
        begin
            if ($urandom_range(0, 1) == 1)
                ck_a = ck_a ^ 8'($urandom_range(1, 255));
            else
                ck_b = ck_b ^ 8'($urandom_range(1, 255));
        end
        push_byte(ck_a);
        push_byte(ck_b);
    endtask

    // Ack-class frame for the awaited class/id, sometimes with one payload byte off.
    task automatic queue_ack_frame(input logic [7:0] id, input bit spoil_ck);
        int pick;
        pick = $urandom_range(0, 9);
        body_q.delete();
        body_q.push_back(rx_cfg.ack_class);
        body_q.push_back(rx_cfg.ack_id);
        if (pick == 0)
            body_q[0] = body_q[0] ^ 8'($urandom_range(1, 255));
        else if (pick == 1)
            body_q[1] = body_q[1] ^ 8'($urandom_range(1, 255));
        queue_frame(gbfr_pkg::CLS_ACK, id, gbfr_pkg::ACK_LEN, spoil_ck);
    endtask

    task automatic queue_random_frame();
        int          kind;
        int          n;
        bit          spoil;
        logic [7:0]  id;
        kind  = $urandom_range(0, 99);
        spoil = ($urandom_range(0, 9) == 0);
        if (kind < 35)
        begin
            // position frames: mostly short, some past the default copy limit
            n = $urandom_range(0, 19);
            if (n < 13)
                n = $urandom_range(0, 24);
            else if (n < 19)
                n = $urandom_range(25, 120);
            else
                n = $urandom_range(121, 400);
            fill_body(n);
            queue_frame(gbfr_pkg::CLS_NAV, gbfr_pkg::ID_PVT, 16'(n), spoil);
        end
        else if (kind < 60)
        begin
            n = $urandom_range(0, 19);
            id = (n < 9) ? gbfr_pkg::ID_ACK : (n < 18) ? gbfr_pkg::ID_NAK :
                 8'($urandom_range(0, 255));
            if ($urandom_range(0, 6) == 0)
            begin
                // random short length, mostly wrong for an ack
                n = $urandom_range(0, 4);
                fill_body(n);
                queue_frame(gbfr_pkg::CLS_ACK, id, 16'(n), spoil);
            end
            else
                queue_ack_frame(id, spoil);
        end
        else if (kind < 75)
        begin
            n = $urandom_range(0, 20);
            fill_body(n);
            id = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                queue_frame(gbfr_pkg::CLS_NAV, (id == gbfr_pkg::ID_PVT) ? gbfr_pkg::ID_ACK : id,
                            16'(n), spoil);
            else
                queue_frame(8'($urandom_range(0, 255)), id, 16'(n), spoil);
        end
        else if (kind < 85)
        begin
            queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        16'($urandom_range(MAX_PAYLOAD + 1, 65535)), 1'b0);
        end
        else if (kind < 95)
        begin
            // line noise between frames, sync bytes likely
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                case ($urandom_range(0, 3))
                    0:       push_noise(gbfr_pkg::SYNC_A);
                    1:       push_noise(gbfr_pkg::SYNC_B);
                    default: push_noise(8'($urandom_range(0, 255)));
                endcase
            end
        end
        else
        begin
            // cut-off frame: the next bytes are taken as its remaining payload or checksum
            push_byte(gbfr_pkg::SYNC_A);
            push_byte(gbfr_pkg::SYNC_B);
            push_byte(8'($urandom_range(0, 255)));
            push_byte(8'($urandom_range(0, 255)));
            push_byte(8'($urandom_range(1, 30)));
            push_byte(8'h00);
            n = $urandom_range(0, 3);
            repeat (n)
                push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Waits until every byte is taken and every expected event has come out.
    task automatic wait_drained();
        @(negedge clk);
        while (rx_pending.size() != 0 || expected_events.size() != 0)
            @(negedge clk);
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Only called with the block idle; the model follows the registers.
    task automatic program_cfg(input logic [7:0] ack_class, input logic [7:0] ack_id,
                               input logic [9:0] copy_limit);
        apb_write(gbfr_pkg::REG_ACK_CLASS, {24'd0, ack_class});
        apb_write(gbfr_pkg::REG_ACK_ID, {24'd0, ack_id});
        apb_write(gbfr_pkg::REG_COPY_LIM, {22'd0, copy_limit});
        rx_cfg.ack_class  = ack_class;
        rx_cfg.ack_id     = ack_id;
        rx_cfg.copy_limit = copy_limit;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        ev_ch.ready   = 1'b0;
        fail_count    = 0;
        frame_bytes   = 0;
        phase_start   = 0;
        rx_fired      = 1'b0;
        quiet_tail    = 1'b0;
        src_gap       = 0;
        src_calm      = 0;
        snk_gap       = 0;
        snk_calm      = 0;
        model_reset();
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: hunting, repeated first sync, empty payload
        push_noise(8'h00);
        push_noise(8'hFF);
        push_noise(gbfr_pkg::SYNC_B);
        push_noise(gbfr_pkg::SYNC_A);
        push_noise(8'h00);
        push_noise(gbfr_pkg::SYNC_A);
        queue_frame(8'hFF, 8'hFF, 16'd0, 1'b0);
        // oversize headers, just over the limit and the largest length
        queue_frame(8'h00, 8'h00, 16'(MAX_PAYLOAD + 1), 1'b0);
        queue_frame(gbfr_pkg::CLS_NAV, gbfr_pkg::ID_PVT, 16'hFFFF, 1'b0);
        // short position frame with extreme bytes, empty one, bad checksum
        body_q = '{8'h00, 8'hFF, 8'h5A};
        queue_frame(gbfr_pkg::CLS_NAV, gbfr_pkg::ID_PVT, 16'd3, 1'b0);
        queue_frame(gbfr_pkg::CLS_NAV, gbfr_pkg::ID_PVT, 16'd0, 1'b0);
        fill_body(2);
        queue_frame(gbfr_pkg::CLS_NAV, gbfr_pkg::ID_PVT, 16'd2, 1'b1);
        // position class, other id
        fill_body(1);
        queue_frame(gbfr_pkg::CLS_NAV, 8'h02, 16'd1, 1'b0);
        // ack, nak, ack with bad checksum, ack class with other id, wrong length
        body_q = '{rx_cfg.ack_class, rx_cfg.ack_id};
        queue_frame(gbfr_pkg::CLS_ACK, gbfr_pkg::ID_ACK, gbfr_pkg::ACK_LEN, 1'b0);
        body_q = '{rx_cfg.ack_class, rx_cfg.ack_id};
        queue_frame(gbfr_pkg::CLS_ACK, gbfr_pkg::ID_NAK, gbfr_pkg::ACK_LEN, 1'b0);
        body_q = '{rx_cfg.ack_class, rx_cfg.ack_id};
        queue_frame(gbfr_pkg::CLS_ACK, gbfr_pkg::ID_ACK, gbfr_pkg::ACK_LEN, 1'b1);
        body_q = '{rx_cfg.ack_class, rx_cfg.ack_id};
        queue_frame(gbfr_pkg::CLS_ACK, 8'h02, gbfr_pkg::ACK_LEN, 1'b0);
        body_q = '{rx_cfg.ack_class, rx_cfg.ack_id, 8'h00};
        queue_frame(gbfr_pkg::CLS_ACK, gbfr_pkg::ID_ACK, 16'd3, 1'b0);

        // Random phases; each one drains fully and idles before the registers change.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained();
            repeat (4)
                @(posedge clk);
            phase_start = frame_bytes;
            case (phase)
                0: program_cfg(8'd0, 8'd0, 10'd0);
                1:
                begin
                    program_cfg(8'd255, 8'd255, 10'(MAX_PAYLOAD));
                    // full-size position frame reaches the top byte index
                    fill_body(MAX_PAYLOAD);
                    queue_frame(gbfr_pkg::CLS_NAV, gbfr_pkg::ID_PVT, 16'(MAX_PAYLOAD), 1'b0);
                end
                2: program_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               10'($urandom_range(0, 120)));
                3: program_cfg(gbfr_pkg::RST_ACK_CLASS, gbfr_pkg::RST_ACK_ID,
                               10'($urandom_range(1, 40)));
                default:
                begin
                    quiet_tail = 1'b1;
                    program_cfg(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                10'($urandom_range(0, MAX_PAYLOAD)));
                end
            endcase
            while (frame_bytes < phase_start + PHASE_BYTES)
                queue_random_frame();
        end

        wait_drained();
        repeat (10)
            @(posedge clk);
        if (fail_count == 0)
            $display("gnss_binary_frame_receiver_tb OK");
        else
            $display("gnss_binary_frame_receiver_tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/gbfr_pkg.sv
rtl/gbfr_ifs.sv
rtl/gbfr_parser.sv
rtl/gnss_binary_frame_receiver.sv
tb/gnss_binary_frame_receiver_tb.sv
